// ----- design/wdiv_pkg.sv -----
// Package with the word types and constants shared by the wide divider files.
`default_nettype none
package wdiv_pkg;

    // Width of every data field on the ports; the overflow flag is a single bit.
    localparam int DATA_BITS = 64;

    // Default number of active bits in each word.
    localparam int WORD_BITS_DEFAULT = 64;

    // One input word: double-width dividend and single-width divisor.
    typedef struct packed {
        logic [DATA_BITS-1:0] dividend_low;
        logic [DATA_BITS-1:0] dividend_high;
        logic [DATA_BITS-1:0] divisor;
    } wdiv_in_t;

    // One result word.
    typedef struct packed {
        logic [DATA_BITS-1:0] quotient;
        logic [DATA_BITS-1:0] remainder;
        logic                 overflow;
    } wdiv_out_t;

endpackage
`default_nettype wire

// ----- design/wdiv_cell.sv -----
// One restoring shift-subtract step of the divider chain, with its own word register.
`default_nettype none
module wdiv_cell #(
    parameter int WORD_BITS = 64
) (
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    // Upstream side.
    input  wire logic                 valid_in,
    output logic                      ready_out,
    input  wire logic [WORD_BITS-1:0] rem_in,
    input  wire logic [WORD_BITS-1:0] lq_in,
    input  wire logic [WORD_BITS-1:0] div_in,
    input  wire logic                 ovf_in,
    // Downstream side.
    output logic                      valid_out,
    input  wire logic                 ready_in,
    output logic [WORD_BITS-1:0]      rem_out,
    output logic [WORD_BITS-1:0]      lq_out,
    output logic [WORD_BITS-1:0]      div_out,
    output logic                      ovf_out
);

    logic                 valid_reg;
    logic [WORD_BITS-1:0] rem_reg;
    logic [WORD_BITS-1:0] lq_reg;
    logic [WORD_BITS-1:0] div_reg;
    logic                 ovf_reg;

    logic                 advance;
    logic                 top_bit;
    logic [WORD_BITS-1:0] rem_shift;
    logic                 take;
    logic [WORD_BITS-1:0] rem_next;
    logic [WORD_BITS-1:0] lq_next;

    // The cell takes a new word when it is empty or its word moves on.
    assign advance   = !valid_reg || ready_in;
    assign ready_out = advance;

    // Shift the next dividend bit into the partial remainder; the bit shifted out
    // of the top makes the remainder exceed the divisor on its own.
    always_comb begin
        top_bit   = rem_in[WORD_BITS-1];
        rem_shift = {rem_in[WORD_BITS-2:0], lq_in[WORD_BITS-1]};
        take      = top_bit || (rem_shift >= div_in);
        rem_next  = take ? (rem_shift - div_in) : rem_shift;
        // Dividend bits leave at the top while quotient bits enter at the bottom.
        lq_next   = {lq_in[WORD_BITS-2:0], take};
    end

    // Control state.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (advance) begin
            valid_reg <= valid_in;
        end
    end

    // Payload registers.
    always_ff @(posedge aclk) begin
        if (advance && valid_in) begin
            rem_reg <= rem_next;
            lq_reg  <= lq_next;
            div_reg <= div_in;
            ovf_reg <= ovf_in;
        end
    end

    assign valid_out = valid_reg;
    assign rem_out   = rem_reg;
    assign lq_out    = lq_reg;
    assign div_out   = div_reg;
    assign ovf_out   = ovf_reg;

endmodule
`default_nettype wire

// ----- design/wide_divide_128_by_64_top.sv -----
// Top level of the pipelined 128-by-64 restoring divider.
//
//  channel | direction | handshake          | word
//  --------+-----------+--------------------+-------------------------------------
//  s_      | in        | s_valid / s_ready  | dividend_low, dividend_high, divisor
//  m_      | out       | m_valid / m_ready  | quotient, remainder, overflow
//
// A chain of WORD_BITS cells does one shift-subtract step each, so one word is
// accepted every cycle while m_ready does not stall the chain; the first cell
// registers its step at the accepting edge, and each later cell's register passes
// the word on in turn to the last cell, whose valid flag drives m_valid.
// Each cell holds its own word; an empty cell takes a word even while later
// cells are stalled, so bubbles close up and the last cell serves as output register.
// Reset (aresetn low, synchronous) empties every cell; no results are pending after it.
// A stalled m_ready holds the result and backs the chain up; s_ready drops only
// once every cell holds a word.
`default_nettype none
module wide_divide_128_by_64_top #(
    parameter int WORD_BITS = wdiv_pkg::WORD_BITS_DEFAULT
) (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              s_valid,
    output logic                   s_ready,
    input  wire wdiv_pkg::wdiv_in_t s_data,
    output logic                   m_valid,
    input  wire logic              m_ready,
    output wdiv_pkg::wdiv_out_t    m_data
);
    import wdiv_pkg::*;

    localparam logic [WORD_BITS-1:0] WORD_MASK = {WORD_BITS{1'b1}};

    // Links between cells; index 0 is the input side.
    logic [WORD_BITS:0]                valid_c;
    logic [WORD_BITS:0]                ready_c;
    logic [WORD_BITS:0][WORD_BITS-1:0] rem_c;
    logic [WORD_BITS:0][WORD_BITS-1:0] lq_c;
    logic [WORD_BITS:0][WORD_BITS-1:0] div_c;
    logic [WORD_BITS:0]                ovf_c;

    logic [WORD_BITS-1:0] lo_word;
    logic [WORD_BITS-1:0] hi_word;
    logic [WORD_BITS-1:0] dv_word;

    // Keep only the active bits of each input field.
    assign lo_word = s_data.dividend_low[WORD_BITS-1:0];
    assign hi_word = s_data.dividend_high[WORD_BITS-1:0];
    assign dv_word = s_data.divisor[WORD_BITS-1:0];

    // Feed the head of the chain; the overflow check runs beside the first step.
    assign valid_c[0] = s_valid;
    assign s_ready    = ready_c[0];
    assign rem_c[0]   = hi_word;
    assign lq_c[0]    = lo_word;
    assign div_c[0]   = dv_word;
    assign ovf_c[0]   = (hi_word >= dv_word);

    // The row of step cells.
    for (genvar i = 0; i < WORD_BITS; i++) begin : g_cell
        wdiv_cell #(
            .WORD_BITS(WORD_BITS)
        ) u_cell (
            .aclk     (aclk),
            .aresetn  (aresetn),
            .valid_in (valid_c[i]),
            .ready_out(ready_c[i]),
            .rem_in   (rem_c[i]),
            .lq_in    (lq_c[i]),
            .div_in   (div_c[i]),
            .ovf_in   (ovf_c[i]),
            .valid_out(valid_c[i+1]),
            .ready_in (ready_c[i+1]),
            .rem_out  (rem_c[i+1]),
            .lq_out   (lq_c[i+1]),
            .div_out  (div_c[i+1]),
            .ovf_out  (ovf_c[i+1])
        );
    end

    // The last cell is the output register.
    assign ready_c[WORD_BITS] = m_ready;
    assign m_valid            = valid_c[WORD_BITS];

    // Overflowed words report an all-ones quotient and a zero remainder.
    always_comb begin
        if (ovf_c[WORD_BITS]) begin
            m_data.quotient  = DATA_BITS'(WORD_MASK);
            m_data.remainder = '0;
            m_data.overflow  = 1'b1;
        end else begin
            m_data.quotient  = DATA_BITS'(lq_c[WORD_BITS]);
            m_data.remainder = DATA_BITS'(rem_c[WORD_BITS]);
            m_data.overflow  = 1'b0;
        end
    end

endmodule
`default_nettype wire

// ----- design/wdiv_checker.sv -----
// Port-level checker for the wide divider, bound to its top level.
`default_nettype none
module wdiv_checker #(
    parameter int WORD_BITS = wdiv_pkg::WORD_BITS_DEFAULT
) (
    input wire logic                aclk,
    input wire logic                aresetn,
    input wire logic                s_valid,
    input wire logic                s_ready,
    input wire wdiv_pkg::wdiv_in_t  s_data,
    input wire logic                m_valid,
    input wire logic                m_ready,
    input wire wdiv_pkg::wdiv_out_t m_data
);
    import wdiv_pkg::*;

    localparam logic [DATA_BITS-1:0] WORD_MASK = DATA_BITS'({WORD_BITS{1'b1}});

    // A stalled result word holds still.
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_data))
        else $error("result word changed while stalled");

    // Overflow carries the fixed quotient and remainder.
    a_ovf_fields: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_data.overflow |->
            m_data.quotient == WORD_MASK && m_data.remainder == '0)
        else $error("overflow word has wrong quotient or remainder");

    // Result fields carry nothing above the active word width.
    a_upper_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_data.quotient & ~WORD_MASK) == '0 &&
                    (m_data.remainder & ~WORD_MASK) == '0)
        else $error("result bits set above the word width");

    // Reset leaves no result pending.
    a_reset_empty: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("result valid right after reset");

endmodule

bind wide_divide_128_by_64_top wdiv_checker #(.WORD_BITS(WORD_BITS)) u_wdiv_checker (.*);
`default_nettype wire

// ----- test/tb_wide_divide_128_by_64_top.sv -----
// Testbench for the pipelined 128-by-64 restoring divider: scoreboard class, drivers, checks.
`timescale 1ns / 100ps
module tb_wide_divide_128_by_64_top;

    import wdiv_pkg::*;

    localparam int WB = WORD_BITS_DEFAULT;
    localparam int RANDOM_WORDS = 1500;
    localparam logic [DATA_BITS-1:0] ALL_ONES = {DATA_BITS{1'b1}};
    localparam logic [DATA_BITS-1:0] TOP_BIT = {1'b1, {(DATA_BITS-1){1'b0}}};

    // Receiver stall patterns.
    typedef enum logic [1:0] {
        READY_ALWAYS,
        READY_RANDOM,
        READY_PERIODIC,
        READY_HOLD
    } ready_mode_e;

    // Scoreboard: predicts each division and checks results in order.
    class divide_scoreboard;
        wdiv_out_t due_results[$];
        int        failures;

        function new();
            failures = 0;
        endfunction

        // Shift-subtract division with a partial remainder that keeps its carry-out bit.
        function wdiv_out_t divide_word(wdiv_in_t w);
            logic [DATA_BITS-1:0] mask;
            logic [DATA_BITS-1:0] lo;
            logic [DATA_BITS-1:0] hi;
            logic [DATA_BITS-1:0] d;
            logic [DATA_BITS-1:0] q;
            logic [DATA_BITS-1:0] r;
            logic                 carry;
            wdiv_out_t            res;
            int                   i;
            mask = ALL_ONES >> (DATA_BITS - WB);
            lo = w.dividend_low & mask;
            hi = w.dividend_high & mask;
            d = w.divisor & mask;
            res = '0;
            if (hi >= d) begin
                res.quotient = mask;
                res.remainder = '0;
                res.overflow = 1'b1;
                return res;
            end
            q = '0;
            r = hi;
            for (i = WB - 1; i >= 0; i--) begin
                carry = r[WB-1];
                r = ((r << 1) | DATA_BITS'(lo[i])) & mask;
                q = (q << 1) & mask;
                if (carry || r >= d) begin
                    r = (r - d) & mask;
                    q[0] = 1'b1;
                end
            end
            res.quotient = q;
            res.remainder = r;
            res.overflow = 1'b0;
            return res;
        endfunction

        function void note_input(wdiv_in_t w);
            due_results.push_back(divide_word(w));
        endfunction

        function void check_result(wdiv_out_t got);
            wdiv_out_t want;
            if (due_results.size() == 0) begin
                if (failures < 10)
                    $display("[%0t] unexpected result q=%h r=%h ovf=%b", $realtime,
                             got.quotient, got.remainder, got.overflow);
                failures++;
                return;
            end
            want = due_results.pop_front();
            if (got.quotient !== want.quotient || got.remainder !== want.remainder ||
                got.overflow !== want.overflow) begin
                if (failures < 10) begin
                    $display("[%0t] result mismatch", $realtime);
                    $display("    quotient  exp %h act %h", want.quotient, got.quotient);
                    $display("    remainder exp %h act %h", want.remainder, got.remainder);
                    $display("    overflow  exp %b act %b", want.overflow, got.overflow);
                end
                failures++;
            end
        endfunction

        function int pending();
            return due_results.size();
        endfunction
    endclass

    logic      aclk = 1'b0;
    logic      aresetn = 1'b0;
    logic      s_valid = 1'b0;
    logic      s_ready;
    wdiv_in_t  s_data = '0;
    logic      m_valid;
    logic      m_ready = 1'b0;
    wdiv_out_t m_data;

    divide_scoreboard sb = new();

    wide_divide_128_by_64_top dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

    always #5 aclk = ~aclk;

    // Both channels are observed at the rising edge.
    always @(posedge aclk) begin
        if (aresetn && s_valid && s_ready)
            sb.note_input(s_data);
        if (aresetn && m_valid && m_ready)
            sb.check_result(m_data);
    end

    // Receiver stalls: a new pattern is picked at the end of each stretch.
    ready_mode_e ready_mode = READY_ALWAYS;
    int          ready_left = 0;
    int          ready_tick = 0;

    always @(negedge aclk) begin
        if (ready_left == 0) begin
            ready_mode <= ready_mode_e'($urandom_range(0, 3));
            ready_left <= $urandom_range(20, 300);
        end else begin
            ready_left <= ready_left - 1;
        end
        ready_tick <= ready_tick + 1;
        case (ready_mode)
            READY_ALWAYS: begin
                m_ready <= 1'b1;
            end
            READY_RANDOM: begin
                m_ready <= ($urandom_range(0, 3) != 0);
            end
            READY_PERIODIC: begin
                m_ready <= ((ready_tick % 7) >= 3);
            end
            default: begin
                m_ready <= (ready_left < 4);
            end
        endcase
    end

    function automatic logic [DATA_BITS-1:0] rand_word();
        return {$urandom(), $urandom()};
    endfunction

    // Presents one word and holds it until the block takes it.
    task automatic send_word(input wdiv_in_t w);
        @(negedge aclk);
        s_valid <= 1'b1;
        s_data <= w;
        do @(posedge aclk); while (!s_ready);
    endtask

    task automatic send_case(input logic [DATA_BITS-1:0] lo, input logic [DATA_BITS-1:0] hi,
                             input logic [DATA_BITS-1:0] d);
        wdiv_in_t w;
        w.dividend_low = lo;
        w.dividend_high = hi;
        w.divisor = d;
        send_word(w);
    endtask

    task automatic idle_cycles(input int n);
        repeat (n) begin
            @(negedge aclk);
            s_valid <= 1'b0;
        end
    endtask

    // Main sequence: reset, directed corners, random bursts, drain.
    initial begin
        wdiv_in_t             w;
        logic [DATA_BITS-1:0] d;
        int                   sent;
        int                   burst;
        int                   pick;
        repeat (3) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // Zero divisor and high word at or above the divisor.
        send_case('0, '0, '0);
        send_case(ALL_ONES, ALL_ONES, '0);
        send_case(64'd5, 64'd1, 64'd1);
        send_case(ALL_ONES, ALL_ONES, ALL_ONES);
        send_case('0, ALL_ONES, 64'd1);
        send_case(ALL_ONES, 64'd2, 64'd2);
        // Quotient fits in one word.
        send_case('0, '0, 64'd1);
        send_case(ALL_ONES, '0, 64'd1);
        send_case(ALL_ONES, '0, ALL_ONES);
        send_case(ALL_ONES, ALL_ONES - 1, ALL_ONES);
        send_case('0, ALL_ONES - 1, ALL_ONES);
        // Partial remainder shifts a one out of the word, then small and patterned cases.
        send_case('0, TOP_BIT, TOP_BIT + 1);
        send_case(ALL_ONES, ~TOP_BIT, TOP_BIT);
        send_case(TOP_BIT, '0, ALL_ONES);
        send_case(64'd1, '0, 64'd2);
        send_case('0, 64'd1, 64'd2);
        send_case({32{2'b10}}, {32{2'b01}}, {32{2'b10}});
        send_case({32{2'b01}}, {32{2'b10}}, ALL_ONES);
        send_case(64'd12345, '0, 64'd7);
        send_case(ALL_ONES, 64'd2, 64'd3);
        idle_cycles(4);

        // Random bursts: mostly in-range dividends, then overflow, zero divisors and high words just below the divisor.
        sent = 0;
        while (sent < RANDOM_WORDS) begin
            burst = $urandom_range(1, 40);
            repeat (burst) begin
                pick = $urandom_range(0, 99);
                w.dividend_low = rand_word();
                if (pick < 70) begin
                    case (pick % 4)
                        0: d = rand_word();
                        1: d = DATA_BITS'($urandom_range(1, 1000));
                        2: d = rand_word() | TOP_BIT;
                        default: d = rand_word() >> $urandom_range(0, 63);
                    endcase
                    if (d == '0)
                        d = 64'd1;
                    w.divisor = d;
                    w.dividend_high = (pick % 5 == 0) ? d - 1 : rand_word() % d;
                end else if (pick < 85) begin
                    d = rand_word() >> $urandom_range(0, 63);
                    w.divisor = d;
                    // A zero divisor would make the span below wrap to zero.
                    w.dividend_high = (pick % 2 == 0 || d == '0) ?
                                      d : d + (rand_word() % (ALL_ONES - d + 1));
                end else if (pick < 90) begin
                    w.divisor = '0;
                    w.dividend_high = rand_word();
                end else begin
                    d = rand_word() | 64'd1;
                    w.divisor = d;
                    w.dividend_high = d - 1;
                    w.dividend_low = (pick % 2 == 0) ? ALL_ONES : '0;
                end
                send_word(w);
                sent++;
            end
            if ($urandom_range(0, 3) != 0)
                idle_cycles($urandom_range(0, 8));
        end
        idle_cycles(1);

        // Wait for the pipeline to drain, then a little longer for strays.
        while (sb.pending() != 0)
            @(posedge aclk);
        repeat (WB + 8) @(posedge aclk);

        if (sb.failures == 0 && sb.pending() == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

    // Watchdog on the whole run.
    initial begin
        #10000000;
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
